/* hw/rtl/a64x_pkg.sv */
// shared types, constants and decode helpers for the a64 execute unit
// no dependencies
package a64x_pkg;

    localparam int NumRegs = 31;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_HALT    = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    localparam logic [31:0] HALT_WORD   = 32'h8A00_0000;
    localparam logic [21:0] BR_PATTERN  = 22'd3508160;
    localparam logic [7:0]  BCOND_TOP   = 8'd84;
    localparam logic [3:0]  RESET_FLAGS = 4'h4;

    // operation classes
    localparam logic [2:0] OP_ADDI  = 3'd0;
    localparam logic [2:0] OP_MOVW  = 3'd1;
    localparam logic [2:0] OP_LOGIC = 3'd2;
    localparam logic [2:0] OP_ADDR  = 3'd3;
    localparam logic [2:0] OP_MADD  = 3'd4;
    localparam logic [2:0] OP_B     = 3'd5;
    localparam logic [2:0] OP_BR    = 3'd6;
    localparam logic [2:0] OP_BCOND = 3'd7;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  op;
        logic [31:0] word;
    } dec_t;

    function automatic logic cond_holds(input logic [3:0] c, input logic [3:0] f);
        logic n, z, v;
        begin
            n = f[3];
            z = f[2];
            v = f[0];
            case (c)
                4'd0:    cond_holds = z;
                4'd1:    cond_holds = !z;
                4'd10:   cond_holds = (n == v);
                4'd11:   cond_holds = (n != v);
                4'd12:   cond_holds = !z && (n == v);
                4'd13:   cond_holds = z || (n != v);
                default: cond_holds = 1'b1;
            endcase
        end
    endfunction

endpackage

/* hw/rtl/a64x_decode.sv */
// front part: takes instruction words, classifies them, flags halt/invalid ones
// depends on a64x_pkg
module a64x_decode
    import a64x_pkg::*;
(
    input  logic [31:0] word,
    output dec_t        dec
);

    logic       is64;
    logic [1:0] opc;
    logic [5:0] amt;
    logic [3:0] cnd;

    always_comb
    begin
        is64 = word[31];
        opc  = word[30:29];
        amt  = word[15:10];
        cnd  = word[3:0];
        dec.word   = word;
        dec.op     = OP_ADDI;
        dec.status = ST_INVALID;
        if (word[28:26] == 3'b100)
        begin
            if (word[25:23] == 3'd2)
            begin
                dec.op = OP_ADDI;
                dec.status = ST_OK;
            end
            else if (word[25:23] == 3'd5)
            begin
                dec.op = OP_MOVW;
                if (!(opc == 2'd1 || (!is64 && word[22])))
                    dec.status = ST_OK;
            end
        end
        else if (word[27:25] == 3'b101)
        begin
            if (word == HALT_WORD)
                dec.status = ST_HALT;
            else if (!word[28])
            begin
                if (!(!is64 && amt[5]))
                begin
                    if (!word[24])
                    begin
                        dec.op = OP_LOGIC;
                        dec.status = ST_OK;
                    end
                    else if (!(word[21] || word[23:22] == 2'd3))
                    begin
                        dec.op = OP_ADDR;
                        dec.status = ST_OK;
                    end
                end
            end
            else if (word[24:21] == 4'd8 && opc == 2'd0)
            begin
                dec.op = OP_MADD;
                dec.status = ST_OK;
            end
        end
        else if (word[29:26] == 4'd5)
        begin
            if (word[31:26] == 6'd5)
            begin
                dec.op = OP_B;
                dec.status = ST_OK;
            end
            else if (word[31:10] == BR_PATTERN && word[4:0] == 5'd0)
            begin
                dec.op = OP_BR;
                dec.status = ST_OK;
            end
            else if (word[31:24] == BCOND_TOP && !word[4])
            begin
                dec.op = OP_BCOND;
                if (cnd == 4'd0 || cnd == 4'd1 || (cnd >= 4'd10 && cnd <= 4'd14))
                    dec.status = ST_OK;
            end
        end
    end

endmodule

/* hw/rtl/a64x_queue.sv */
// two-entry queue between the decode front and the execute back
// depends on a64x_pkg
module a64x_queue
    import a64x_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  dec_t push_data,
    output logic full,
    input  logic pop,
    output logic empty,
    output dec_t head
);

    dec_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign head  = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

/* hw/rtl/a64x_execute.sv */
// back part: executes one classified instruction a cycle against the architectural state
// unless a madd/msub or a held result stalls it; depends on a64x_pkg
module a64x_execute
    import a64x_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  dec_t        dec,
    output logic        in_take,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [63:0] next_pc,
    output logic        reg_write,
    output logic [4:0]  reg_index,
    output logic [63:0] reg_value,
    output logic [3:0]  flags_nzcv
);

    logic [63:0] rf_reg [NumRegs];
    logic [3:0]  flags_reg;
    logic [63:0] pc_reg;
    logic        ov_reg;
    logic [1:0]  st_reg;
    logic [63:0] npc_reg, val_reg;
    logic        wr_reg;
    logic [4:0]  idx_reg;
    logic [3:0]  nz_reg;
    logic        mul_reg;
    logic [63:0] pll_reg;
    logic [31:0] pcr_reg;

    logic [31:0] w;
    logic        is64;
    logic [63:0] m, a, b, c, rdv, op2, sh, res, prod, addb, sum;
    logic [64:0] s65;
    logic [32:0] s33;
    logic        cin, cy, top;
    logic [5:0]  amt;
    logic [63:0] imm, npc, off;
    logic [3:0]  f;
    logic        wr;
    logic [1:0]  st;
    logic [63:0] pll;
    logic [31:0] pcr;
    logic        mul_wait;

    function automatic logic [63:0] rdr(input logic [4:0] i, input logic [63:0] r [NumRegs]);
        rdr = (i == 5'd31) ? 64'd0 : r[i];
    endfunction

    // madd/msub first registers its partial products before it is taken
    assign mul_wait = (dec.op == OP_MADD) && !mul_reg;
    assign in_take  = in_valid && !mul_wait && (!ov_reg || !out_stall);

    always_comb
    begin
        w    = dec.word;
        is64 = w[31];
        m    = is64 ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
        a    = rdr(w[9:5], rf_reg) & m;
        b    = rdr(w[20:16], rf_reg) & m;
        c    = rdr(w[14:10], rf_reg);
        rdv  = rdr(w[4:0], rf_reg);
        amt  = w[15:10];
        // shifter for register operand
        sh = b;
        if (amt != 6'd0)
        begin
            case (w[23:22])
                2'd0:    sh = (b << amt) & m;
                2'd1:    sh = b >> amt;
                2'd2:    sh = is64 ? 64'($signed(b) >>> amt)
                                   : {32'd0, 32'($signed(b[31:0]) >>> amt[4:0])};
                default: sh = is64 ? ((b >> amt) | (b << (7'd64 - {1'b0, amt})))
                                   : {32'd0, (b[31:0] >> amt[4:0])
                                             | (b[31:0] << (6'd32 - amt))};
            endcase
        end
        imm  = w[22] ? {40'd0, w[21:10], 12'd0} : {52'd0, w[21:10]};
        addb = (dec.op == OP_ADDI) ? imm : sh;
        cin  = w[30];
        addb = (cin ? ~addb : addb) & m;
        s65  = {1'b0, a} + {1'b0, addb} + {64'd0, cin};
        s33  = {1'b0, a[31:0]} + {1'b0, addb[31:0]} + {32'd0, cin};
        sum  = s65[63:0] & m;
        cy   = is64 ? s65[64] : s33[32];
        // low 64 bits of the product from 32-bit partial products
        pll  = {32'd0, a[31:0]} * {32'd0, b[31:0]};
        pcr  = (a[31:0] * b[63:32]) + (a[63:32] * b[31:0]);
        prod = pll_reg + {pcr_reg, 32'd0};
        op2  = w[21] ? (~sh & m) : sh;
        res  = 64'd0;
        f    = flags_reg;
        wr   = 1'b0;
        top  = 1'b0;
        npc  = pc_reg + 64'd4;
        st   = dec.status;
        off  = 64'd0;
        case (dec.op)
            OP_ADDI, OP_ADDR:
            begin
                res = sum;
                wr  = 1'b1;
                top = is64 ? sum[63] : sum[31];
                if (w[29])
                    f = {top, sum == 64'd0, cy,
                         is64 ? ((a[63] ^ sum[63]) & (addb[63] ^ sum[63]))
                              : ((a[31] ^ sum[31]) & (addb[31] ^ sum[31]))};
            end
            OP_MOVW:
            begin
                imm = {48'd0, w[20:5]} << {w[22:21], 4'd0};
                case (w[30:29])
                    2'd0:    res = ~imm;
                    2'd2:    res = imm;
                    default: res = (rdv & ~(64'hFFFF << {w[22:21], 4'd0})) | imm;
                endcase
                wr = 1'b1;
            end
            OP_LOGIC:
            begin
                case (w[30:29])
                    2'd0:    res = a & op2;
                    2'd1:    res = a | op2;
                    2'd2:    res = a ^ op2;
                    default:
                    begin
                        res = a & op2 & m;
                        f = {is64 ? res[63] : res[31], res == 64'd0, 2'b00};
                    end
                endcase
                wr = 1'b1;
            end
            OP_MADD:
            begin
                res = w[15] ? (c - prod) : (c + prod);
                wr  = 1'b1;
            end
            OP_B:
            begin
                off = {{36{w[25]}}, w[25:0], 2'b00};
                npc = pc_reg + off;
            end
            OP_BR:
                npc = rdr(w[9:5], rf_reg);
            default:
            begin
                off = {{43{w[23]}}, w[23:5], 2'b00};
                if (cond_holds(w[3:0], flags_reg))
                    npc = pc_reg + off;
            end
        endcase
        res = res & m;
        if (w[4:0] == 5'd31)
            wr = 1'b0;
        if (st != ST_OK)
        begin
            npc = pc_reg;
            wr  = 1'b0;
            f   = flags_reg;
        end
        if (!wr)
            res = 64'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NumRegs; i++)
                rf_reg[i] <= 64'd0;
            flags_reg <= RESET_FLAGS;
            pc_reg    <= 64'd0;
            ov_reg    <= 1'b0;
            mul_reg   <= 1'b0;
        end
        else
        begin
            if (in_take)
                mul_reg <= 1'b0;
            else if (in_valid && mul_wait)
                mul_reg <= 1'b1;
            if (in_take)
            begin
                ov_reg <= 1'b1;
                if (st == ST_OK)
                begin
                    pc_reg    <= npc;
                    flags_reg <= f;
                    if (wr)
                        rf_reg[w[4:0]] <= res;
                end
            end
            else if (!out_stall)
                ov_reg <= 1'b0;
        end
    end

    // partial products; operands hold since nothing retires meanwhile
    always_ff @(posedge clk)
    begin
        if (in_valid && mul_wait)
        begin
            pll_reg <= pll;
            pcr_reg <= pcr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            st_reg  <= st;
            npc_reg <= npc;
            wr_reg  <= wr;
            idx_reg <= wr ? w[4:0] : 5'd0;
            val_reg <= res;
            nz_reg  <= f;
        end
    end

    assign out_valid  = ov_reg;
    assign status     = st_reg;
    assign next_pc    = npc_reg;
    assign reg_write  = wr_reg;
    assign reg_index  = idx_reg;
    assign reg_value  = val_reg;
    assign flags_nzcv = nz_reg;

endmodule

/* hw/rtl/aarch64_subset_execute_unit.sv */
// top level of the a64 integer execute unit: decode front, queue, execute back
// depends on a64x_pkg, a64x_decode, a64x_queue, a64x_execute
//
// one request is one 32-bit a64 instruction word and gives exactly one result carrying
// status, next pc, register write and flags. the front classifies the word in the same
// cycle it is taken and pushes it into a two-entry queue; the back executes one
// instruction a cycle from the queue head against 31 registers, nzcv and pc, unless
// a pending result is held by out_stall, and registers the result. madd and msub
// hold the back while the 32-bit partial products of the multiply are registered;
// everything else runs at one instruction per cycle while out_stall does not hold
// a result. a request goes from the queue entry to the result registers. in_stall
// rises only when the queue is full.
module aarch64_subset_execute_unit
    import a64x_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] instruction_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [63:0] next_pc,
    output logic        reg_write,
    output logic [4:0]  reg_index,
    output logic [63:0] reg_value,
    output logic [3:0]  flags_nzcv
);

    dec_t dec, head;
    logic full, empty, take, push;

    // classify the incoming word
    a64x_decode u_dec (
        .word (instruction_word),
        .dec  (dec)
    );

    assign in_stall = full;
    assign push     = in_valid && !full;

    a64x_queue u_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (dec),
        .full      (full),
        .pop       (take),
        .empty     (empty),
        .head      (head)
    );

    a64x_execute u_ex (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (!empty),
        .dec        (head),
        .in_take    (take),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .next_pc    (next_pc),
        .reg_write  (reg_write),
        .reg_index  (reg_index),
        .reg_value  (reg_value),
        .flags_nzcv (flags_nzcv)
    );

    // a write result never targets register 31
    a_no_x31: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(reg_write && reg_index == 5'd31))
        else $error("write to register 31");

    // non-ok results never write
    a_bad_nowr: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> !reg_write)
        else $error("write on halt or invalid");

    // queue never pops when empty
    a_pop: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> !empty)
        else $error("pop from empty queue");

endmodule

/* test/testbench.sv */
// self-checking testbench for aarch64_subset_execute_unit
// depends on a64x_pkg and the execute unit rtl; holds its own a64 predictor and scoreboard
module testbench;
    import a64x_pkg::*;

    typedef struct {
        logic [1:0]  status;
        logic [63:0] next_pc;
        logic        reg_write;
        logic [4:0]  reg_index;
        logic [63:0] reg_value;
        logic [3:0]  flags_nzcv;
    } a64_result_t;

    // architectural shadow of the unit plus the queue of pending results
    class a64_scoreboard;
        logic [63:0] regs[NumRegs];
        logic [3:0]  nzcv;
        logic [63:0] pc;
        a64_result_t pending[$];
        int          errors;

        function void clear();
            foreach (regs[i]) regs[i] = '0;
            nzcv = RESET_FLAGS;
            pc = '0;
            errors = 0;
        endfunction

        function logic [63:0] rdreg(input logic [4:0] i);
            return (i < NumRegs) ? regs[i] : 64'd0;
        endfunction

        function logic [63:0] width_mask(input logic is64);
            return is64 ? {64{1'b1}} : 64'h0000_0000_FFFF_FFFF;
        endfunction

        function logic [63:0] shift_op(input logic [63:0] v, input logic [1:0] kind,
                                       input int amt, input logic is64);
            logic [63:0] m;
            int w;
            m = width_mask(is64);
            w = is64 ? 64 : 32;
            v = v & m;
            if (amt == 0) return v;
            case (kind)
                2'd0: return (v << amt) & m;
                2'd1: return v >> amt;
                2'd2: return (v[w-1]) ? ((v >> amt) | (m & ~(m >> amt))) : (v >> amt);
                default: return ((v >> amt) | (v << (w - amt))) & m;
            endcase
        endfunction

        // add or subtract with carry and overflow at the operand width
        function logic [63:0] add_sub(input logic [63:0] a, input logic [63:0] b,
                                      input logic sub, input logic is64,
                                      output logic [3:0] f);
            logic [64:0] s;
            logic [63:0] m, r;
            logic c;
            int top;
            m = width_mask(is64);
            top = is64 ? 63 : 31;
            a = a & m;
            b = (sub ? ~b : b) & m;
            s = {1'b0, a} + {1'b0, b} + {64'd0, sub};
            if (is64)
            begin
                r = s[63:0];
                c = s[64];
            end
            else
            begin
                r = s[63:0] & m;
                c = s[32];
            end
            f = {r[top], r == 64'd0, c, (a[top] ^ r[top]) & (b[top] ^ r[top])};
            return r;
        endfunction

        function logic [63:0] sext_words(input logic [63:0] off, input int bits);
            off = off & ((64'd1 << bits) - 1);
            if (off[bits-1]) off = off | ~((64'd1 << bits) - 1);
            return off << 2;
        endfunction

        function void note_request(input logic [31:0] w);
            a64_result_t o;
            logic is64;
            logic [1:0] opc, kind;
            logic [4:0] rd;
            logic [63:0] a, b, r, imm, op2;
            logic [3:0] f, c;
            int amt, sh;
            logic [1:0] st;
            is64 = w[31];
            opc = w[30:29];
            rd = w[4:0];
            kind = w[23:22];
            amt = w[15:10];
            o.status = ST_OK;
            o.next_pc = pc + 64'd4;
            o.reg_write = 1'b0;
            o.reg_index = '0;
            o.reg_value = '0;
            o.flags_nzcv = nzcv;
            st = ST_OK;
            r = '0;
            a = rdreg(w[9:5]);
            b = rdreg(w[20:16]);
            if (w[28:26] == 3'd4)
            begin
                if (w[25:23] == 3'd2)
                begin
                    imm = {52'd0, w[21:10]};
                    if (w[22]) imm = imm << 12;
                    r = add_sub(a, imm, opc[1], is64, f);
                    if (opc[0]) o.flags_nzcv = f;
                    o.reg_write = 1'b1;
                end
                else if (w[25:23] == 3'd5)
                begin
                    if (opc == 2'd1 || (!is64 && w[22])) st = ST_INVALID;
                    else
                    begin
                        sh = w[22:21] * 16;
                        imm = {48'd0, w[20:5]} << sh;
                        if (opc == 2'd0) r = ~imm;
                        else if (opc == 2'd2) r = imm;
                        else r = (rdreg(rd) & ~(64'hFFFF << sh)) | imm;
                        o.reg_write = 1'b1;
                    end
                end
                else st = ST_INVALID;
            end
            else if (w[27:25] == 3'd5)
            begin
                if (w == HALT_WORD) st = ST_HALT;
                else if (!w[28])
                begin
                    if (!is64 && amt >= 32) st = ST_INVALID;
                    else if (!w[24])
                    begin
                        op2 = shift_op(b, kind, amt, is64);
                        if (w[21]) op2 = ~op2 & width_mask(is64);
                        case (opc)
                            2'd0: r = a & op2;
                            2'd1: r = a | op2;
                            2'd2: r = a ^ op2;
                            default:
                            begin
                                r = a & op2 & width_mask(is64);
                                o.flags_nzcv = {is64 ? r[63] : r[31], r == 64'd0, 2'b00};
                            end
                        endcase
                        o.reg_write = 1'b1;
                    end
                    else if (w[21] || kind == 2'd3) st = ST_INVALID;
                    else
                    begin
                        r = add_sub(a, shift_op(b, kind, amt, is64), opc[1], is64, f);
                        if (opc[0]) o.flags_nzcv = f;
                        o.reg_write = 1'b1;
                    end
                end
                else if (w[24:21] != 4'd8 || opc != 2'd0) st = ST_INVALID;
                else
                begin
                    r = w[15] ? rdreg(w[14:10]) - a * b : rdreg(w[14:10]) + a * b;
                    o.reg_write = 1'b1;
                end
            end
            else if (w[29:26] == 4'd5)
            begin
                c = w[3:0];
                if (w[31:26] == 6'd5) o.next_pc = pc + sext_words(w[25:0], 26);
                else if (w[31:10] == BR_PATTERN && w[4:0] == 5'd0) o.next_pc = a;
                else if (w[31:24] == BCOND_TOP && !w[4])
                begin
                    if (c != 4'd0 && c != 4'd1 && (c < 4'd10 || c > 4'd14)) st = ST_INVALID;
                    else if (cond_ok(c, nzcv)) o.next_pc = pc + sext_words(w[23:5], 19);
                end
                else st = ST_INVALID;
            end
            else st = ST_INVALID;

            // register 31 discards the write
            if (o.reg_write && rd < NumRegs)
            begin
                o.reg_index = rd;
                o.reg_value = r & width_mask(is64);
            end
            else o.reg_write = 1'b0;

            if (st != ST_OK)
            begin
                o.next_pc = pc;
                o.reg_write = 1'b0;
                o.reg_index = '0;
                o.reg_value = '0;
                o.flags_nzcv = nzcv;
            end
            else
            begin
                pc = o.next_pc;
                nzcv = o.flags_nzcv;
                if (o.reg_write) regs[o.reg_index] = o.reg_value;
            end
            o.status = st;
            pending.push_back(o);
        endfunction

        function logic cond_ok(input logic [3:0] c, input logic [3:0] f);
            case (c)
                4'd0:  return f[2];
                4'd1:  return !f[2];
                4'd10: return f[3] == f[0];
                4'd11: return f[3] != f[0];
                4'd12: return !f[2] && f[3] == f[0];
                4'd13: return f[2] || f[3] != f[0];
                default: return 1'b1;
            endcase
        endfunction

        function void check_result(input a64_result_t got);
            a64_result_t want;
            if (pending.size() == 0)
            begin
                $error("unexpected result, status %0d", got.status);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status)
            begin
                $error("status expected %0d actual %0d", want.status, got.status);
                errors++;
            end
            if (got.next_pc !== want.next_pc)
            begin
                $error("next_pc expected %h actual %h", want.next_pc, got.next_pc);
                errors++;
            end
            if (got.reg_write !== want.reg_write)
            begin
                $error("reg_write expected %0d actual %0d", want.reg_write, got.reg_write);
                errors++;
            end
            if (got.reg_index !== want.reg_index)
            begin
                $error("reg_index expected %0d actual %0d", want.reg_index, got.reg_index);
                errors++;
            end
            if (got.reg_value !== want.reg_value)
            begin
                $error("reg_value expected %h actual %h", want.reg_value, got.reg_value);
                errors++;
            end
            if (got.flags_nzcv !== want.flags_nzcv)
            begin
                $error("flags_nzcv expected %h actual %h", want.flags_nzcv, got.flags_nzcv);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] instruction_word;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [63:0] next_pc;
    logic        reg_write;
    logic [4:0]  reg_index;
    logic [63:0] reg_value;
    logic [3:0]  flags_nzcv;

    a64_scoreboard exec_model;
    int send_idle_pct;
    int recv_idle_pct;
    logic stim_done;

    aarch64_subset_execute_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .instruction_word(instruction_word),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .next_pc(next_pc),
        .reg_write(reg_write),
        .reg_index(reg_index),
        .reg_value(reg_value),
        .flags_nzcv(flags_nzcv)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // present one request, with an optional random gap first, and hold it until taken
    task automatic send_request(input logic [31:0] w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        instruction_word <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        exec_model.note_request(w);
    endtask

    // random register number, sometimes register 31 (zero / discard)
    function automatic logic [4:0] pick_reg();
        return ($urandom_range(9) == 0) ? 5'd31 : 5'($urandom_range(7));
    endfunction

    // mostly well-formed instructions from the subset, some noise
    function automatic logic [31:0] random_instr();
        logic [31:0] w;
        logic [3:0] conds[7];
        conds = '{4'd0, 4'd1, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14};
        w = $urandom;
        case ($urandom_range(11))
            0, 1: w = {w[31:30], w[29], 6'b100010, w[22:10], pick_reg(), pick_reg()};
            2: w = {w[31:29], 6'b100101, w[22:5], pick_reg()};
            3, 4: w = {w[31:29], 5'b01010, w[23:21], pick_reg(),
                       w[31] ? w[15:10] : {1'b0, w[14:10]}, pick_reg(), pick_reg()};
            5, 6: w = {w[31:29], 5'b01011, w[23:22], 1'b0, pick_reg(),
                       w[31] ? w[15:10] : {1'b0, w[14:10]}, pick_reg(), pick_reg()};
            7: w = {w[31], 7'b00_11011, 3'b000, pick_reg(), w[15], pick_reg(), pick_reg(),
                    pick_reg()};
            8: w = {6'b000101, (w[25] ? 26'h3FF_FFF0 : 26'h10) ^ {20'd0, w[5:0]}};
            9: w = {BCOND_TOP, (w[23] ? 19'h7FFF0 : 19'h8) ^ {13'd0, w[10:5]}, 1'b0,
                    conds[$urandom_range(6)]};
            10: w = {BR_PATTERN, pick_reg(), 5'd0};
            default: ;
        endcase
        return w;
    endfunction

    initial
    begin
        logic [31:0] directed[$];
        rst_n = 1'b0;
        in_valid = 1'b0;
        instruction_word = '0;
        stim_done = 1'b0;
        send_idle_pct = 37;
        recv_idle_pct = 85;
        exec_model = new();
        exec_model.clear();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed = '{
            32'hD29FFFE1,  // movz x1,#0xffff
            32'hF2FFFFE1,  // movk x1 top half
            32'h92800002,  // movn x2,#0
            32'hB1000423,  // adds x3,x1,#1
            32'h71000440,  // subs w0,w2,#1
            32'hEB02003F,  // cmp x1,x2 into register 31
            32'hAB428424,  // adds x4,x1,x2,lsr #33
            32'hCB823C25,  // sub x5,x1,x2,asr #15
            32'hCAC2FC26,  // eor x6,x1,x2,ror #63
            32'hEA220027,  // bics x7,x1,x2
            32'hAAE20028,  // orn x8,x1,x2,ror
            32'h9B020829,  // madd x9,x1,x2,x2
            32'h9B02882A,  // msub x10,x1,x2,x2
            32'h2B007C20,  // adds w0 shift 31
            32'h2B008020,  // 32-bit shift 32: invalid
            32'h72A00000,  // movk w hw 1
            32'h52C00000,  // 32-bit movz hw 2: invalid
            32'h12800000,  // movn w0,#0
            32'h8BC00000,  // add shift type 11: invalid
            32'h54000020,  // b.eq forward
            32'h5400002F,  // b.nv: invalid
            32'h17FFFFFF,  // b backwards
            32'hD61F0120,  // br x9
            32'hF9400000,  // load: invalid
            HALT_WORD
        };
        foreach (directed[i]) send_request(directed[i]);

        for (int i = 0; i < 950; i++)
        begin
            if (i == 320) begin send_idle_pct = 85; recv_idle_pct = 37; end
            if (i == 640) begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            send_request(random_instr());
        end
        in_valid <= 1'b0;
        stim_done <= 1'b1;
    end

    // receiver: random stall, check every result taken
    initial
    begin
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                exec_model.check_result('{status, next_pc, reg_write, reg_index,
                                          reg_value, flags_nzcv});
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    initial
    begin
        wait (stim_done);
        while (exec_model.pending.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (exec_model.errors == 0 && exec_model.pending.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial
    begin
        #4000000;
        $display("tb: failure");
        $finish;
    end

endmodule

/* aarch64_subset_execute_unit.f */
hw/rtl/a64x_pkg.sv
hw/rtl/a64x_decode.sv
hw/rtl/a64x_queue.sv
hw/rtl/a64x_execute.sv
hw/rtl/aarch64_subset_execute_unit.sv
test/testbench.sv
